// ===== rtl/sitc_pkg.sv =====
// ----------------------------------------------------------------------------
// sitc_pkg: shared types and constants of the spiral index converter
// Field widths, register map, and the command and status bundles that run
// between the controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package sitc_pkg;

	// field widths
	localparam int unsigned PosW  = 30;
	localparam int unsigned SideW = 15;
	localparam int unsigned RootW = 15;            // floor(sqrt(2^30-1)) < 2^15
	localparam int unsigned RemW  = RootW + 2;     // remainder <= 2*root
	localparam int unsigned OddW  = RootW + 1;     // rounded-up odd root
	localparam int unsigned SqW   = 2 * OddW;

	// largest side used; larger register values are clamped to it
	localparam logic [SideW:0] MaxSide = 16'd32767;

	// one square-root step per result bit
	localparam int unsigned RootSteps = RootW;
	localparam int unsigned CntW      = $clog2(RootSteps);

	// stream payload widths
	localparam int unsigned InDataW  = 32;
	localparam int unsigned OutDataW = 32;

	// register map
	localparam int unsigned AddrW    = 3;
	localparam int unsigned DataW    = 32;
	localparam logic        RegGridSide = 1'b0;   // index taken from paddr[2]

	// controller to datapath
	typedef struct packed {
		logic load_in;     // capture position and clamped side
		logic check;       // range check, clear result, start root
		logic root_step;   // one square-root digit
		logic round;       // round root up to odd, derive ring
		logic square;      // square the odd root
		logic corner;      // ring corners and line/column bounds
		logic select;      // pick the side, form the coordinates
		logic load_out;    // move the result to the output register
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad;         // position outside the grid
		logic out_free;    // output register can take a result
	} status_t;

endpackage

`default_nettype wire

// ===== rtl/sitc_ctrl.sv =====
// ----------------------------------------------------------------------------
// sitc_ctrl: sequencing controller
// One-hot state machine that steps one request through range check, the
// bit-serial square root, ring derivation, side selection and output.
// ----------------------------------------------------------------------------
`default_nettype none

module sitc_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	input  sitc_pkg::status_t status,
	output sitc_pkg::cmd_t    cmd
);

	typedef enum logic [7:0] {
		ST_IDLE   = 8'b0000_0001,
		ST_CHECK  = 8'b0000_0010,
		ST_ROOT   = 8'b0000_0100,
		ST_ROUND  = 8'b0000_1000,
		ST_SQUARE = 8'b0001_0000,
		ST_CORNER = 8'b0010_0000,
		ST_SELECT = 8'b0100_0000,
		ST_OUTPUT = 8'b1000_0000
	} state_t;

	localparam logic [sitc_pkg::CntW-1:0] LastStep =
		sitc_pkg::CntW'(sitc_pkg::RootSteps - 1);

	state_t                    state_q, state_d;
	logic [sitc_pkg::CntW-1:0] cnt_q;

	assign in_ready = (state_q == ST_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_CHECK;
				end
			end
			ST_CHECK: begin
				cmd.check = 1'b1;
				state_d   = status.bad ? ST_OUTPUT : ST_ROOT;
			end
			ST_ROOT: begin
				cmd.root_step = 1'b1;
				if (cnt_q == LastStep)
					state_d = ST_ROUND;
			end
			ST_ROUND: begin
				cmd.round = 1'b1;
				state_d   = ST_SQUARE;
			end
			ST_SQUARE: begin
				cmd.square = 1'b1;
				state_d    = ST_CORNER;
			end
			ST_CORNER: begin
				cmd.corner = 1'b1;
				state_d    = ST_SELECT;
			end
			ST_SELECT: begin
				cmd.select = 1'b1;
				state_d    = ST_OUTPUT;
			end
			ST_OUTPUT: begin
				// hold while the previous result is still unclaimed
				if (status.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// state and root step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_ROOT)
				cnt_q <= (cnt_q == LastStep) ? '0 : cnt_q + 1'b1;
			else
				cnt_q <= '0;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/sitc_datapath.sv =====
// ----------------------------------------------------------------------------
// sitc_datapath: arithmetic of the spiral index converter
// Range check, restoring square root one digit per cycle, ring corners,
// side selection, and the output register of the result stream.
// ----------------------------------------------------------------------------
`default_nettype none

module sitc_datapath (
	input  wire                            clk,
	input  wire                            arst_n,
	input  sitc_pkg::cmd_t                 cmd,
	output sitc_pkg::status_t              status,
	input  wire [sitc_pkg::PosW-1:0]       pos_in,
	input  wire [sitc_pkg::SideW-1:0]      grid_side,
	input  wire                            m_tready,
	output logic                           m_tvalid,
	output logic [sitc_pkg::OutDataW-1:0]  m_tdata,
	output logic                           m_tuser
);

	localparam int unsigned PosW  = sitc_pkg::PosW;
	localparam int unsigned SideW = sitc_pkg::SideW;
	localparam int unsigned RootW = sitc_pkg::RootW;
	localparam int unsigned RemW  = sitc_pkg::RemW;
	localparam int unsigned OddW  = sitc_pkg::OddW;
	localparam int unsigned SqW   = sitc_pkg::SqW;

	// working registers
	logic [PosW-1:0]  pos_q;
	logic [PosW-1:0]  rad_q;
	logic [SideW-1:0] side_q;
	logic             bad_q;
	logic [RemW-1:0]  rem_q;
	logic [RootW-1:0] root_q;
	logic [OddW-1:0]  odd_q;
	logic [SideW-1:0] k_q;
	logic [SqW-1:0]   sq_q;
	logic [SqW-1:0]   ul_q, ll_q, lr_q;
	logic [SideW-1:0] lo_q, hi_q;
	logic [SideW-1:0] row_q, col_q;
	logic             out_bad_q;
	logic [SideW-1:0] out_row_q, out_col_q;

	// clamp of the side register
	logic [SideW-1:0] side_clamped;
	assign side_clamped = ({1'b0, grid_side} > sitc_pkg::MaxSide) ?
		sitc_pkg::MaxSide[SideW-1:0] : grid_side;

	// range check
	logic [PosW-1:0] area;
	logic            bad;
	assign area = PosW'(side_q) * PosW'(side_q);
	assign bad  = (pos_q == '0) || (pos_q > area);

	// one restoring square-root digit
	logic [RemW+1:0] rem_shift;
	logic [RemW+1:0] trial;
	logic            take;
	logic [RemW+1:0] rem_diff;
	assign rem_shift = {rem_q, rad_q[PosW-1 -: 2]};
	assign trial     = (RemW+2)'({root_q, 2'b01});
	assign take      = (rem_shift >= trial);
	assign rem_diff  = rem_shift - trial;

	// round up to the next odd root
	logic [OddW-1:0] ceil_root;
	logic [OddW-1:0] odd_root;
	assign ceil_root = {1'b0, root_q} + OddW'(rem_q != '0);
	assign odd_root  = ceil_root | OddW'(1);

	// ring corners: lr = sq-2k, ll = sq-4k, ul = sq-6k
	logic [SqW-1:0]   k2, k4, k6;
	logic [SideW-1:0] center;
	assign k2     = SqW'({k_q, 1'b0});
	assign k4     = SqW'({k_q, 2'b00});
	assign k6     = k2 + k4;
	assign center = (side_q >> 1) + SideW'(side_q[0]);

	// side selection: offsets in 15-bit modular arithmetic, comparisons at full width
	logic [SqW-1:0]   pos_w;
	logic [SideW-1:0] d_ul, d_ll, d_lr, d_sq;
	assign pos_w = SqW'(pos_q);
	assign d_ul  = ul_q[SideW-1:0] - pos_q[SideW-1:0];
	assign d_ll  = ll_q[SideW-1:0] - pos_q[SideW-1:0];
	assign d_lr  = lr_q[SideW-1:0] - pos_q[SideW-1:0];
	assign d_sq  = sq_q[SideW-1:0] - pos_q[SideW-1:0];

	logic [SideW-1:0] row_sel, col_sel;
	always_comb begin
		if (pos_w <= ul_q) begin
			row_sel = hi_q;
			col_sel = lo_q + d_ul;
		end else if (pos_w <= ll_q) begin
			row_sel = lo_q + d_ll;
			col_sel = lo_q;
		end else if (pos_w <= lr_q) begin
			row_sel = lo_q;
			col_sel = hi_q - d_lr;
		end else begin
			row_sel = hi_q - d_sq;
			col_sel = hi_q;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			pos_q  <= pos_in;
			rad_q  <= pos_in;
			side_q <= side_clamped;
		end
		if (cmd.check) begin
			bad_q  <= bad;
			rem_q  <= '0;
			root_q <= '0;
			row_q  <= '0;
			col_q  <= '0;
		end
		if (cmd.root_step) begin
			rad_q  <= rad_q << 2;
			rem_q  <= take ? RemW'(rem_diff) : RemW'(rem_shift);
			root_q <= {root_q[RootW-2:0], take};
		end
		if (cmd.round) begin
			odd_q <= odd_root;
			k_q   <= odd_root[OddW-1:1];
		end
		if (cmd.square)
			sq_q <= SqW'(odd_q) * SqW'(odd_q);
		if (cmd.corner) begin
			lr_q <= sq_q - k2;
			ll_q <= sq_q - k4;
			ul_q <= sq_q - k6;
			lo_q <= center - k_q;
			hi_q <= center + k_q;
		end
		if (cmd.select) begin
			row_q <= row_sel;
			col_q <= col_sel;
		end
		if (cmd.load_out) begin
			out_row_q <= row_q;
			out_col_q <= col_q;
			out_bad_q <= bad_q;
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else begin
			if (cmd.load_out)
				m_tvalid <= 1'b1;
			else if (m_tready)
				m_tvalid <= 1'b0;
		end
	end

	assign m_tdata = sitc_pkg::OutDataW'({out_col_q, out_row_q});
	assign m_tuser = out_bad_q;

	assign status.bad      = bad;
	assign status.out_free = !m_tvalid || m_tready;

endmodule

`default_nettype wire

// ===== rtl/spiral_index_to_coordinate.sv =====
// ----------------------------------------------------------------------------
// spiral_index_to_coordinate: square spiral position to grid line and column
// Usage:
//   Input stream s_*: s_tdata[29:0] carries a one-based spiral position.
//   Output stream m_*: m_tdata carries line (bits 14:0, counted from the
//   bottom) and column (bits 29:15, counted from the left); m_tuser flags a
//   position of zero or beyond side squared, with both coordinates zero.
//   Register grid_side (byte address 0, 15 bits, reset 1) sets the grid side;
//   write it only while no request is in flight.
// Timing:
//   One request is in work at a time; s_tready is high only when idle.
//   An in-range position passes the range check, the digit-serial square root,
//   rounding, squaring, corner, side-select and output steps before it shows
//   on m_tvalid. An out-of-range position goes from the range check straight
//   to the output step. The next request is taken in the cycle after the
//   result moves into the output register.
//   If the receiver stalls, the result waits in the output register and a
//   following request runs up to its output step, then holds.
// Reset: arst_n clears the controller and output valid and sets grid_side 1.
// ----------------------------------------------------------------------------
`default_nettype none

module spiral_index_to_coordinate (
	input  wire                           clk,
	input  wire                           arst_n,
	// input stream
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [sitc_pkg::InDataW-1:0]   s_tdata,   // [29:0] spiral_position
	// output stream
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [sitc_pkg::OutDataW-1:0] m_tdata,   // [14:0] line_index, [29:15] column_index
	output logic                          m_tuser,   // [0] out_of_range
	// configuration port
	input  wire                           psel,
	input  wire                           penable,
	input  wire                           pwrite,
	input  wire [sitc_pkg::AddrW-1:0]     paddr,
	input  wire [sitc_pkg::DataW-1:0]     pwdata,
	output logic [sitc_pkg::DataW-1:0]    prdata,
	output logic                          pready
);

	sitc_pkg::cmd_t    cmd;
	sitc_pkg::status_t status;

	logic [sitc_pkg::SideW-1:0] grid_side_q;
	logic                       reg_write;

	// configuration register
	assign pready    = 1'b1;
	assign reg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= sitc_pkg::SideW'(1);
		end else if (reg_write && (paddr[2] == sitc_pkg::RegGridSide)) begin
			grid_side_q <= pwdata[sitc_pkg::SideW-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == sitc_pkg::RegGridSide)
			prdata = sitc_pkg::DataW'(grid_side_q);
	end

	// controller
	sitc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	// datapath
	sitc_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.pos_in    (s_tdata[sitc_pkg::PosW-1:0]),
		.grid_side (grid_side_q),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	// checks
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("flagged result carries nonzero coordinates");

	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while one is in work");

	a_cfg_write: assert property (@(posedge clk) disable iff (!arst_n)
		reg_write && (paddr[2] == sitc_pkg::RegGridSide) |=>
		grid_side_q == $past(pwdata[sitc_pkg::SideW-1:0]))
		else $error("grid side register not updated by write");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !m_tvalid || m_tready)
		else $error("result overwrote an unclaimed output");

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench: spiral position to grid coordinate converter
// Drives spiral positions over the input stream under a range of grid sides
// written through the register port. An in-bench scoreboard works out the
// expected line, column and out-of-range flag for each accepted request and
// checks every result in order. Both stream sides idle at random, and the
// receiver holds off once long enough to stall the input.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sitc_pkg::AddrW-1:0] GridSideAddr = {sitc_pkg::RegGridSide, 2'b00};
	localparam int unsigned DrainCycles = 30;     // further wait once no result is pending
	localparam int unsigned HoldCycles  = 400;
	localparam int unsigned PhaseItems  = 144;

	// corners of the outermost ring at the largest side
	localparam int unsigned OuterRing  = 16383;
	localparam int unsigned OuterSq    = 32767 * 32767;
	localparam int unsigned OuterLr    = OuterSq - 2 * OuterRing;
	localparam int unsigned OuterLl    = OuterSq - 4 * OuterRing;
	localparam int unsigned OuterUl    = OuterLl - 2 * OuterRing;
	localparam int unsigned OuterFirst = 32765 * 32765 + 1;

	typedef struct packed {
		logic                       out_of_range;
		logic [sitc_pkg::SideW-1:0] column;
		logic [sitc_pkg::SideW-1:0] line;
	} coord_t;

	// expected coordinates of accepted requests, oldest first
	class spiral_scoreboard;
		bit [sitc_pkg::SideW-1:0] grid_side = 1;
		coord_t                   expected_q[$];
		int unsigned              requests;
		int unsigned              results;
		int unsigned              flagged;
		int unsigned              mismatches;

		function coord_t place_on_spiral(bit [sitc_pkg::PosW-1:0] pos);
			longint unsigned side, p, root, probe, step, ring, sq, ul, ll, lr;
			longint          center, lo, hi, row, col;
			coord_t          res;
			side = 64'(grid_side);
			if (side > sitc_pkg::MaxSide) begin
				side = 64'(sitc_pkg::MaxSide);
			end
			p   = 64'(pos);
			row = 0;
			col = 0;
			res = '0;
			if (p == 0 || p > side * side) begin
				res.out_of_range = 1'b1;
			end else begin
				// floor square root, then up to the odd bound of the ring
				root = 0;
				for (step = 64'd1 << 30; step != 0; step >>= 1) begin
					probe = root | step;
					if (probe * probe <= p) begin
						root = probe;
					end
				end
				if (root * root < p) begin
					root++;
				end
				if (!root[0]) begin
					root++;
				end
				ring = (root - 1) / 2;
				sq   = root * root;
				ll   = sq - 4 * ring;
				ul   = ll - 2 * ring;
				lr   = sq - 2 * ring;

				center = longint'((side + 1) / 2);
				lo     = center - longint'(ring);
				hi     = center + longint'(ring);

				// top, left, bottom, right side of the ring
				if (p <= ul) begin
					row = hi;
					col = lo + longint'(ul - p);
				end else if (p <= ll) begin
					row = lo + longint'(ll - p);
					col = lo;
				end else if (p <= lr) begin
					row = lo;
					col = hi - longint'(lr - p);
				end else begin
					row = hi - longint'(sq - p);
					col = hi;
				end
			end
			res.line   = row[sitc_pkg::SideW-1:0];
			res.column = col[sitc_pkg::SideW-1:0];
			return res;
		endfunction

		function void note_request(bit [sitc_pkg::PosW-1:0] pos);
			coord_t c;
			c = place_on_spiral(pos);
			if (c.out_of_range) begin
				flagged++;
			end
			requests++;
			expected_q.push_back(c);
		endfunction

		function void report(string what, longint unsigned want,
		                     longint unsigned got);
			mismatches++;
			if (mismatches <= 10) begin
				$display("[%0t] mismatch on %s: expected %0d, got %0d",
				         $time, what, want, got);
			end
		endfunction

		function void check_result(coord_t got);
			coord_t want;
			results++;
			if (expected_q.size() == 0) begin
				report("result with no request waiting (line)", 64'd0, 64'(got.line));
				return;
			end
			want = expected_q.pop_front();
			if (got.line != want.line) begin
				report("line_index", 64'(want.line), 64'(got.line));
			end
			if (got.column != want.column) begin
				report("column_index", 64'(want.column), 64'(got.column));
			end
			if (got.out_of_range != want.out_of_range) begin
				report("out_of_range", 64'(want.out_of_range), 64'(got.out_of_range));
			end
		endfunction

		function int unsigned pending();
			return expected_q.size();
		endfunction
	endclass

	bit                            clk;
	logic                          arst_n   = 1'b0;
	logic                          s_tvalid = 1'b0;
	logic                          s_tready;
	logic [sitc_pkg::InDataW-1:0]  s_tdata  = '0;    // [29:0] spiral_position
	logic                          m_tvalid;
	logic                          m_tready = 1'b0;
	logic [sitc_pkg::OutDataW-1:0] m_tdata;          // [14:0] line_index, [29:15] column_index
	logic                          m_tuser;          // [0] out_of_range
	logic                          psel     = 1'b0;
	logic                          penable  = 1'b0;
	logic                          pwrite   = 1'b0;
	logic [sitc_pkg::AddrW-1:0]    paddr    = '0;
	logic [sitc_pkg::DataW-1:0]    pwdata   = '0;
	logic [sitc_pkg::DataW-1:0]    prdata;
	logic                          pready;

	bit                            steady;           // no idling on either side
	int unsigned                   hold_reqs;        // long hold-offs asked of the receiver
	int unsigned                   configs;

	spiral_scoreboard              sb = new();

	spiral_index_to_coordinate u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// hang guard
	initial begin
		#10_000_000;
		$display("testbench failed");
		$finish;
	end

	// stream monitor: results first, then new requests
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				sb.check_result(coord_t'{out_of_range: m_tuser,
				    column: m_tdata[2*sitc_pkg::SideW-1:sitc_pkg::SideW],
				    line: m_tdata[sitc_pkg::SideW-1:0]});
			end
			if (s_tvalid && s_tready) begin
				sb.note_request(s_tdata[sitc_pkg::PosW-1:0]);
			end
		end
	end

	// receiver: random ready runs, long hold-off on request
	initial begin : sink_side
		int unsigned run_left, hold_left, hold_seen, r;
		bit          take;
		run_left  = 0;
		hold_left = 0;
		hold_seen = 0;
		take      = 1'b1;
		forever begin
			@(posedge clk);
			if (hold_reqs != hold_seen) begin
				hold_seen = hold_reqs;
				hold_left = HoldCycles;
			end
			if (hold_left != 0) begin
				hold_left--;
				take = 1'b0;
			end else if (steady) begin
				take     = 1'b1;
				run_left = 0;
			end else begin
				if (run_left == 0) begin
					r = $urandom_range(99);
					if (r < 70) begin
						take     = 1'b1;
						run_left = $urandom_range(8, 1);
					end else if (r < 95) begin
						take     = 1'b0;
						run_left = $urandom_range(3, 1);
					end else begin
						take     = 1'b0;
						run_left = $urandom_range(40, 10);
					end
				end
				run_left--;
			end
			m_tready <= take;
		end
	end

	// mostly short gaps, a few long ones
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(3, 1);
		end else if (r < 97) begin
			return $urandom_range(12, 4);
		end
		return $urandom_range(60, 20);
	endfunction

	// positions: mostly inside the grid, some near ring corners, some outside
	function automatic bit [sitc_pkg::PosW-1:0] pick_position(int unsigned side);
		int unsigned area, ring, odd, pos, sel;
		area = side * side;
		sel  = $urandom_range(99);
		if (area == 0 || sel < 10) begin
			case ($urandom_range(3))
				0:       pos = 0;
				1:       pos = area + 1;
				2:       pos = $urandom_range(32'h3FFF_FFFF, area + 1);
				default: pos = $urandom();
			endcase
		end else if (sel < 20) begin
			pos = $urandom();
		end else if (sel < 40) begin
			ring = $urandom_range((side - 1) / 2);
			odd  = 2 * ring + 1;
			pos  = odd * odd - 2 * ring * $urandom_range(3) + $urandom_range(2) - 1;
			if (pos == 0) begin
				pos = 1;
			end
		end else begin
			pos = $urandom_range(area, 1);
		end
		return pos[sitc_pkg::PosW-1:0];
	endfunction

	// one request, then a random gap
	task automatic offer(input bit [sitc_pkg::PosW-1:0] pos);
		int unsigned gap;
		s_tdata  <= {{(sitc_pkg::InDataW-sitc_pkg::PosW){1'b0}}, pos};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		gap = steady ? 0 : pick_gap();
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop sending and let every result come back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic read_back(input bit [sitc_pkg::SideW-1:0] want);
		paddr   <= GridSideAddr;
		pwrite  <= 1'b0;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata != {{(sitc_pkg::DataW-sitc_pkg::SideW){1'b0}}, want}) begin
			sb.report("grid_side read", 64'(want), 64'(prdata));
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic write_grid_side(input bit [sitc_pkg::SideW-1:0] side);
		paddr   <= GridSideAddr;
		pwdata  <= {{(sitc_pkg::DataW-sitc_pkg::SideW){1'b0}}, side};
		pwrite  <= 1'b1;
		psel    <= 1'b1;
		penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		sb.grid_side = side;
		configs++;
		@(posedge clk);
		read_back(side);
	endtask

	// random requests under one grid side
	task automatic run_phase(input bit [sitc_pkg::SideW-1:0] side, input bit calm,
	                         input bit squeeze);
		write_grid_side(side);
		steady = calm;
		for (int i = 0; i < PhaseItems; i++) begin
			if (squeeze && i == PhaseItems / 4) begin
				hold_reqs++;
			end
			offer(pick_position(32'(side)));
		end
		steady = 1'b0;
		wait_drained();
	endtask

	// main sequence
	initial begin : main_flow
		int unsigned list[$];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset side of one: center, zero, just outside, all ones
		read_back(1);
		list = '{0, 1, 2, 32'h3FFF_FFFF};
		foreach (list[i]) offer(sitc_pkg::PosW'(list[i]));
		wait_drained();

		// side five: center, ends of the inner ring, every corner of the outer ring, just past the grid
		write_grid_side(5);
		list = '{1, 2, 9, 10, 13, 17, 21, 24, 25, 26};
		foreach (list[i]) offer(sitc_pkg::PosW'(list[i]));
		wait_drained();

		// largest side: corners of the outer ring and the grid edge
		write_grid_side(15'h7FFF);
		list = '{OuterFirst, OuterUl, OuterUl + 1, OuterLr, OuterSq, OuterSq + 1};
		foreach (list[i]) offer(sitc_pkg::PosW'(list[i]));
		wait_drained();

		// even side: center rounds down, coordinates can reach zero
		write_grid_side(4);
		list = '{10, 16, 17};
		foreach (list[i]) offer(sitc_pkg::PosW'(list[i]));
		wait_drained();

		// zero side flags everything
		write_grid_side(0);
		offer(1);
		wait_drained();

		// random phases over small, even, odd and extreme sides
		run_phase(0, 1'b0, 1'b0);
		run_phase(3, 1'b0, 1'b0);
		run_phase(5, 1'b0, 1'b0);
		run_phase(4, 1'b0, 1'b0);
		run_phase(2, 1'b0, 1'b0);
		run_phase(7, 1'b1, 1'b0);
		run_phase(15'h7FFF, 1'b0, 1'b1);
		run_phase(15'h7FFE, 1'b0, 1'b0);
		run_phase(sitc_pkg::SideW'($urandom_range(99, 9) | 1), 1'b0, 1'b0);
		run_phase(sitc_pkg::SideW'($urandom_range(32765, 101) | 1), 1'b0, 1'b0);
		run_phase(16385, 1'b0, 1'b0);
		run_phase(1, 1'b0, 1'b0);

		$display("Covered %0d positions under %0d grid side settings, %0d outside the grid.",
		         sb.requests, configs, sb.flagged);
		$display("Checked %0d results, %0d mismatches, %0d still waiting.",
		         sb.results, sb.mismatches, sb.pending());
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

`default_nettype wire

// ===== files.f =====
rtl/sitc_pkg.sv
rtl/sitc_ctrl.sv
rtl/sitc_datapath.sv
rtl/spiral_index_to_coordinate.sv
dv/testbench.sv
